>>> hdl/obstacle_backup_spin_sequencer_core_assert.svh
// Assertion macros for the sequencer RTL.
`ifndef OBSTACLE_BACKUP_SPIN_SEQUENCER_CORE_ASSERT_SVH
`define OBSTACLE_BACKUP_SPIN_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OBSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OBSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/obss_pkg.sv
`timescale 1ns / 1ps
package obss_pkg;

   // Item kinds.
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_RANGE  = 2'd1;
   localparam logic [1:0] OP_YAW    = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Mode codes.
   localparam logic [2:0] MODE_FORWARD = 3'd0;
   localparam logic [2:0] MODE_BACKUP  = 3'd1;
   localparam logic [2:0] MODE_PAUSE1  = 3'd2;
   localparam logic [2:0] MODE_SPIN    = 3'd3;
   localparam logic [2:0] MODE_PAUSE2  = 3'd4;

   // Register indexes.
   localparam logic [2:0] REG_OBSTACLE_DISTANCE = 3'd0;
   localparam logic [2:0] REG_CRUISE_SPEED      = 3'd1;
   localparam logic [2:0] REG_REVERSE_SPEED     = 3'd2;
   localparam logic [2:0] REG_SPIN_RATE         = 3'd3;
   localparam logic [2:0] REG_BACKUP_TICKS      = 3'd4;
   localparam logic [2:0] REG_PAUSE_TICKS       = 3'd5;
   localparam logic [2:0] REG_SPIN_TIMEOUT      = 3'd6;
   localparam logic [2:0] REG_SPIN_TARGET       = 3'd7;

   // Register reset values.
   localparam logic [15:0]       RST_OBSTACLE_DISTANCE = 16'd400;
   localparam logic signed [11:0] RST_CRUISE_SPEED     = 12'sd300;
   localparam logic signed [11:0] RST_REVERSE_SPEED    = -12'sd300;
   localparam logic signed [11:0] RST_SPIN_RATE        = 12'sd500;
   localparam logic [9:0]        RST_BACKUP_TICKS      = 10'd40;
   localparam logic [9:0]        RST_PAUSE_TICKS       = 10'd10;
   localparam logic [9:0]        RST_SPIN_TIMEOUT      = 10'd600;
   localparam logic [15:0]       RST_SPIN_TARGET       = 16'd32246;

   localparam logic [9:0]         TICK_MAX = 10'd1023;
   localparam logic signed [17:0] TURN_MAX = 18'sh1FFFF;
   localparam logic signed [17:0] TURN_MIN = 18'sh20000;

   typedef struct packed {
      logic [15:0]        obstacle_distance_mm;
      logic signed [11:0] cruise_speed;
      logic signed [11:0] reverse_speed;
      logic signed [11:0] spin_rate;
      logic [9:0]         backup_ticks;
      logic [9:0]         pause_ticks;
      logic [9:0]         spin_timeout_ticks;
      logic [15:0]        spin_target;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        range_mm;
      logic               range_finite;
      logic signed [15:0] yaw_angle;
   } item_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [9:0]         ticks_in_mode;
      logic               obstacle_flag;
      logic               spin_primed;
      logic signed [15:0] previous_yaw;
      logic signed [17:0] turned_angle;
   } state_type;

   typedef struct packed {
      logic               emit;
      logic signed [11:0] linear_cmd;
      logic signed [11:0] angular_cmd;
      logic [2:0]         mode_now;
   } result_type;

endpackage

>>> hdl/obss_csr.sv
`timescale 1ns / 1ps
module obss_csr
   import obss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_OBSTACLE_DISTANCE: cfg_in.obstacle_distance_mm = csr_write_data;
            REG_CRUISE_SPEED:      cfg_in.cruise_speed = csr_write_data[11:0];
            REG_REVERSE_SPEED:     cfg_in.reverse_speed = csr_write_data[11:0];
            REG_SPIN_RATE:         cfg_in.spin_rate = csr_write_data[11:0];
            REG_BACKUP_TICKS:      cfg_in.backup_ticks = csr_write_data[9:0];
            REG_PAUSE_TICKS:       cfg_in.pause_ticks = csr_write_data[9:0];
            REG_SPIN_TIMEOUT:      cfg_in.spin_timeout_ticks = csr_write_data[9:0];
            REG_SPIN_TARGET:       cfg_in.spin_target = csr_write_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_distance_mm <= RST_OBSTACLE_DISTANCE;
         cfg_ff.cruise_speed         <= RST_CRUISE_SPEED;
         cfg_ff.reverse_speed        <= RST_REVERSE_SPEED;
         cfg_ff.spin_rate            <= RST_SPIN_RATE;
         cfg_ff.backup_ticks         <= RST_BACKUP_TICKS;
         cfg_ff.pause_ticks          <= RST_PAUSE_TICKS;
         cfg_ff.spin_timeout_ticks   <= RST_SPIN_TIMEOUT;
         cfg_ff.spin_target          <= RST_SPIN_TARGET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/obss_step.sv
`timescale 1ns / 1ps
module obss_step
   import obss_pkg::*;
(
   input  cfg_type    cfg,
   input  item_type   item,
   input  state_type  cur,
   output state_type  nxt,
   output result_type res
);

   logic [9:0]         tick_sat;
   logic signed [15:0] yaw_delta;
   logic signed [18:0] turn_sum;
   logic signed [17:0] turn_sat;
   logic [17:0]        turn_mag;

   // Tick count after the increment, before any mode change clears it.
   assign tick_sat = (cur.ticks_in_mode == TICK_MAX) ? TICK_MAX
                                                     : cur.ticks_in_mode + 10'd1;

   // Heading difference wraps in 16 bits, which is the angle normalization.
   assign yaw_delta = item.yaw_angle - cur.previous_yaw;
   assign turn_sum  = {cur.turned_angle[17], cur.turned_angle}
                    + {{3{yaw_delta[15]}}, yaw_delta};

   always_comb begin
      if (turn_sum[18] != turn_sum[17]) begin
         turn_sat = turn_sum[18] ? TURN_MIN : TURN_MAX;
      end else begin
         turn_sat = turn_sum[17:0];
      end
   end

   assign turn_mag = turn_sat[17] ? 18'(-turn_sat) : 18'(turn_sat);

   always_comb begin
      nxt             = cur;
      res.emit        = 1'b0;
      res.linear_cmd  = '0;
      res.angular_cmd = '0;
      unique case (item.operation)
         OP_TICK: begin
            nxt.ticks_in_mode = tick_sat;
            if (cur.obstacle_flag && cur.mode == MODE_FORWARD) begin
               nxt.mode          = MODE_BACKUP;
               nxt.ticks_in_mode = '0;
            end else begin
               unique case (cur.mode)
                  MODE_FORWARD: begin
                     res.emit       = 1'b1;
                     res.linear_cmd = cfg.cruise_speed;
                  end
                  MODE_BACKUP: begin
                     res.emit       = 1'b1;
                     res.linear_cmd = cfg.reverse_speed;
                     if (tick_sat >= cfg.backup_ticks) begin
                        nxt.mode          = MODE_PAUSE1;
                        nxt.ticks_in_mode = '0;
                     end
                  end
                  MODE_PAUSE1: begin
                     res.emit = 1'b1;
                     if (tick_sat >= cfg.pause_ticks) begin
                        nxt.mode          = MODE_SPIN;
                        nxt.ticks_in_mode = '0;
                        nxt.spin_primed   = 1'b0;
                        nxt.turned_angle  = '0;
                     end
                  end
                  MODE_SPIN: begin
                     if (tick_sat > cfg.spin_timeout_ticks) begin
                        res.emit          = 1'b1;
                        nxt.mode          = MODE_PAUSE2;
                        nxt.ticks_in_mode = '0;
                     end
                  end
                  MODE_PAUSE2: begin
                     res.emit = 1'b1;
                     if (tick_sat >= cfg.pause_ticks) begin
                        nxt.obstacle_flag = 1'b0;
                        nxt.mode          = MODE_FORWARD;
                        nxt.ticks_in_mode = '0;
                     end
                  end
                  default: begin
                     res.emit = 1'b0;
                  end
               endcase
            end
         end
         OP_RANGE: begin
            if (item.range_finite && cur.mode == MODE_FORWARD
                && item.range_mm < cfg.obstacle_distance_mm) begin
               nxt.obstacle_flag = 1'b1;
               res.emit          = 1'b1;
            end
         end
         OP_YAW: begin
            if (cur.mode == MODE_SPIN) begin
               nxt.previous_yaw = item.yaw_angle;
               if (!cur.spin_primed) begin
                  nxt.spin_primed = 1'b1;
               end else begin
                  nxt.turned_angle = turn_sat;
                  res.emit         = 1'b1;
                  if (turn_mag >= {2'b00, cfg.spin_target}) begin
                     nxt.mode          = MODE_PAUSE2;
                     nxt.ticks_in_mode = '0;
                  end else begin
                     res.angular_cmd = cfg.spin_rate;
                  end
               end
            end
         end
         default: begin
            res.emit = 1'b0;
         end
      endcase
      res.mode_now = nxt.mode;
   end

endmodule

>>> hdl/obstacle_backup_spin_sequencer_core.sv
`timescale 1ns / 1ps
`include "obstacle_backup_spin_sequencer_core_assert.svh"
// Obstacle-avoid sequencer (forward, backup, pause, spin, pause). One transaction
// is accepted per clock unless the input side stalls; each goes through an input
// register and then compare/add logic that updates the mode state and loads the
// result register, which presents the result once the result side is free. The tick
// that moves forward mode into backup, spin ticks before the timeout, range samples
// that are not a finite near range in forward mode, yaw samples outside spin, the
// first yaw sample of a spin and unknown operations give no result. The input side
// stalls only while both the input and result registers are full and the result
// side is stalled. The user must write registers only while the block is idle; the
// block itself does not enforce it.
module obstacle_backup_spin_sequencer_core
   import obss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [15:0]        req_range_mm,
   input  logic               req_range_finite,
   input  logic signed [15:0] req_yaw_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [11:0] rsp_linear_cmd,
   output logic signed [11:0] rsp_angular_cmd,
   output logic [2:0]         rsp_mode_now,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   logic       item_valid_in;
   state_type  state_ff;
   state_type  state_in;
   result_type step_res;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic signed [11:0] linear_ff;
   logic signed [11:0] angular_ff;
   logic [2:0]         mode_now_ff;
   logic       req_accept;
   logic       out_free;
   logic       advance;

   obss_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   obss_step u_step (
      .cfg  (cfg),
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (step_res)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = item_valid_ff && out_free;
   assign req_stall  = item_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = step_res.emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '{mode: MODE_FORWARD, default: '0};
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.operation    <= req_operation;
         item_ff.range_mm     <= req_range_mm;
         item_ff.range_finite <= req_range_finite;
         item_ff.yaw_angle    <= req_yaw_angle;
      end
      if (advance && step_res.emit) begin
         linear_ff   <= step_res.linear_cmd;
         angular_ff  <= step_res.angular_cmd;
         mode_now_ff <= step_res.mode_now;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_linear_cmd  = linear_ff;
   assign rsp_angular_cmd = angular_ff;
   assign rsp_mode_now    = mode_now_ff;

   `OBSS_ASSERT_NEXT(a_emit_shows, clock, reset, advance && step_res.emit, rsp_valid, "result lost")
   `OBSS_ASSERT_NOW(a_no_overrun, clock, reset, req_accept && item_valid_ff, advance, "input overrun")
   `OBSS_ASSERT_NEXT(a_spin_entry, clock, reset, advance && state_ff.mode != MODE_SPIN && state_in.mode == MODE_SPIN, state_ff.turned_angle == '0 && !state_ff.spin_primed, "spin entry not cleared")
   `OBSS_ASSERT_NEXT(a_flag_clear, clock, reset, advance && state_ff.mode == MODE_PAUSE2 && state_in.mode == MODE_FORWARD, !state_ff.obstacle_flag, "obstacle flag kept")

endmodule

>>> tb/sv/obstacle_backup_spin_sequencer_core_test.sv
`timescale 1ns / 1ps
module obstacle_backup_spin_sequencer_core_test;
   import obss_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = '0;
   logic [15:0]        req_range_mm = '0;
   logic               req_range_finite = 1'b0;
   logic signed [15:0] req_yaw_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [11:0] rsp_linear_cmd;
   logic signed [11:0] rsp_angular_cmd;
   logic [2:0]         rsp_mode_now;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_write_data = '0;

   obstacle_backup_spin_sequencer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_range_mm     (req_range_mm),
      .req_range_finite (req_range_finite),
      .req_yaw_angle    (req_yaw_angle),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_linear_cmd   (rsp_linear_cmd),
      .rsp_angular_cmd  (rsp_angular_cmd),
      .rsp_mode_now     (rsp_mode_now),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   item_type   pending_items[$];
   result_type expected_cmds[$];
   int         planned_items = 0;
   int         error_count = 0;
   bit         item_taken = 1'b0;
   bit         idle_on = 1'b1;
   int         send_gap = 0;
   int         stall_left = 0;
   item_type   taken_item;
   result_type next_cmd;
   result_type due_cmd;

   // Sequencer state and register copy used for prediction.
   cfg_type            seq_cfg;
   logic [2:0]         seq_mode;
   logic [9:0]         seq_ticks;
   logic               seq_obstacle;
   logic               seq_primed;
   logic signed [15:0] seq_last_yaw;
   logic signed [17:0] seq_turned;

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   function automatic void switch_mode(logic [2:0] next_mode);
      if (next_mode != seq_mode) begin
         seq_mode = next_mode;
         seq_ticks = '0;
         if (next_mode == MODE_SPIN) begin
            seq_primed = 1'b0;
            seq_turned = '0;
         end
      end
   endfunction

   function automatic result_type motion_cmd(logic signed [11:0] lin, logic signed [11:0] ang);
      result_type cmd;
      cmd.emit = 1'b1;
      cmd.linear_cmd = lin;
      cmd.angular_cmd = ang;
      cmd.mode_now = seq_mode;
      return cmd;
   endfunction

   // Advances the sequencer by one transaction; returns 1 when a command is produced.
   function automatic bit advance_sequencer(input item_type it, output result_type cmd);
      logic signed [15:0] delta;
      int turned;
      int magnitude;
      cmd = '0;
      case (it.operation)
         OP_TICK: begin
            if (seq_ticks != TICK_MAX)
               seq_ticks = seq_ticks + 10'd1;
            if (seq_obstacle && seq_mode == MODE_FORWARD) begin
               switch_mode(MODE_BACKUP);
               return 1'b0;
            end
            case (seq_mode)
               MODE_FORWARD: cmd = motion_cmd(seq_cfg.cruise_speed, '0);
               MODE_BACKUP: begin
                  if (seq_ticks >= seq_cfg.backup_ticks)
                     switch_mode(MODE_PAUSE1);
                  cmd = motion_cmd(seq_cfg.reverse_speed, '0);
               end
               MODE_PAUSE1: begin
                  if (seq_ticks >= seq_cfg.pause_ticks)
                     switch_mode(MODE_SPIN);
                  cmd = motion_cmd('0, '0);
               end
               MODE_SPIN: begin
                  if (seq_ticks <= seq_cfg.spin_timeout_ticks)
                     return 1'b0;
                  switch_mode(MODE_PAUSE2);
                  cmd = motion_cmd('0, '0);
               end
               MODE_PAUSE2: begin
                  if (seq_ticks >= seq_cfg.pause_ticks) begin
                     seq_obstacle = 1'b0;
                     switch_mode(MODE_FORWARD);
                  end
                  cmd = motion_cmd('0, '0);
               end
               default: return 1'b0;
            endcase
            return 1'b1;
         end
         OP_RANGE: begin
            if (!it.range_finite || seq_mode != MODE_FORWARD
                || it.range_mm >= seq_cfg.obstacle_distance_mm)
               return 1'b0;
            seq_obstacle = 1'b1;
            cmd = motion_cmd('0, '0);
            return 1'b1;
         end
         OP_YAW: begin
            if (seq_mode != MODE_SPIN)
               return 1'b0;
            if (!seq_primed) begin
               seq_last_yaw = it.yaw_angle;
               seq_primed = 1'b1;
               return 1'b0;
            end
            // The 16-bit difference wraps, which normalizes the angle for free.
            delta = it.yaw_angle - seq_last_yaw;
            seq_last_yaw = it.yaw_angle;
            turned = int'(seq_turned) + int'(delta);
            if (turned > int'(TURN_MAX))
               turned = int'(TURN_MAX);
            if (turned < int'(TURN_MIN))
               turned = int'(TURN_MIN);
            seq_turned = turned[17:0];
            magnitude = (turned < 0) ? -turned : turned;
            if (magnitude >= int'(seq_cfg.spin_target)) begin
               switch_mode(MODE_PAUSE2);
               cmd = motion_cmd('0, '0);
            end else begin
               cmd = motion_cmd('0, seq_cfg.spin_rate);
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Input side: a transaction is taken when valid is high and stall is low.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         taken_item = pending_items.pop_front();
         if (advance_sequencer(taken_item, next_cmd))
            expected_cmds.push_back(next_cmd);
         item_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !item_taken)) begin
         item_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 16);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_operation <= pending_items[0].operation;
            req_range_mm <= pending_items[0].range_mm;
            req_range_finite <= pending_items[0].range_finite;
            req_yaw_angle <= pending_items[0].yaw_angle;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected command lin %0d ang %0d mode %0d",
                                      rsp_linear_cmd, rsp_angular_cmd, rsp_mode_now));
         end else begin
            due_cmd = expected_cmds.pop_front();
            if (rsp_linear_cmd !== due_cmd.linear_cmd)
               report_mismatch($sformatf("linear_cmd %0d, expected %0d",
                                         rsp_linear_cmd, due_cmd.linear_cmd));
            if (rsp_angular_cmd !== due_cmd.angular_cmd)
               report_mismatch($sformatf("angular_cmd %0d, expected %0d",
                                         rsp_angular_cmd, due_cmd.angular_cmd));
            if (rsp_mode_now !== due_cmd.mode_now)
               report_mismatch($sformatf("mode_now %0d, expected %0d",
                                         rsp_mode_now, due_cmd.mode_now));
         end
      end
   end

   task automatic write_register(logic [2:0] index, logic [15:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Unused upper data bits carry junk; the block must keep the low bits only.
   task automatic load_settings(cfg_type c);
      logic [5:0] junk;
      junk = 6'($urandom);
      write_register(REG_OBSTACLE_DISTANCE, c.obstacle_distance_mm);
      write_register(REG_CRUISE_SPEED, {junk[3:0], c.cruise_speed});
      write_register(REG_REVERSE_SPEED, {junk[5:2], c.reverse_speed});
      write_register(REG_SPIN_RATE, {junk[4:1], c.spin_rate});
      write_register(REG_BACKUP_TICKS, {junk, c.backup_ticks});
      write_register(REG_PAUSE_TICKS, {junk[2:0], junk[5:3], c.pause_ticks});
      write_register(REG_SPIN_TIMEOUT, {junk[0], junk[5:1], c.spin_timeout_ticks});
      write_register(REG_SPIN_TARGET, c.spin_target);
      seq_cfg = c;
   endtask

   function automatic cfg_type random_settings();
      cfg_type c;
      c.obstacle_distance_mm = 16'($urandom);
      c.cruise_speed = 12'($urandom);
      c.reverse_speed = 12'($urandom);
      c.spin_rate = 12'($urandom);
      c.backup_ticks = 10'($urandom_range(0, 8));
      c.pause_ticks = 10'($urandom_range(0, 6));
      c.spin_timeout_ticks = 10'($urandom_range(0, 40));
      case ($urandom_range(0, 2))
         0: c.spin_target = 16'($urandom_range(0, 2000));
         1: c.spin_target = 16'($urandom);
         default: c.spin_target = 16'($urandom_range(60000, 65535));
      endcase
      return c;
   endfunction

   // Waits until every transaction is taken and every command has come back,
   // then lets the pipeline drain of transactions that produce nothing.
   task automatic settle();
      while (pending_items.size() != 0 || expected_cmds.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic push_item(logic [1:0] op, logic [15:0] range_mm, logic finite,
                            logic signed [15:0] yaw);
      item_type it;
      it.operation = op;
      it.range_mm = range_mm;
      it.range_finite = finite;
      it.yaw_angle = yaw;
      pending_items.push_back(it);
      planned_items++;
   endtask

   task automatic push_step(logic [1:0] op, logic [15:0] range_mm, logic finite,
                            logic signed [15:0] yaw);
      logic [15:0] noise_range;
      logic signed [15:0] noise_yaw;
      if ($urandom_range(0, 5) == 0) begin
         noise_range = 16'($urandom);
         noise_yaw = 16'($urandom);
         push_item(2'($urandom_range(0, 3)), noise_range, 1'($urandom_range(0, 1)),
                   noise_yaw);
      end
      push_item(op, range_mm, finite, yaw);
   endtask

   task automatic push_ticks(int n);
      repeat (n) push_step(OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
   endtask

   function automatic int ticks_for(logic [9:0] v);
      if (v == 0)
         return 1;
      return (v > 60) ? 60 : int'(v);
   endfunction

   // One obstacle encounter: cruise, near range, backup, pause, spin, pause.
   task automatic plan_avoidance_cycle();
      int n;
      int step;
      int span;
      int sign;
      int turn_est;
      logic signed [15:0] heading;
      logic signed [15:0] wrapped;
      logic [15:0] near_limit;
      near_limit = seq_cfg.obstacle_distance_mm;
      n = $urandom_range(0, 4);
      repeat (n) begin
         push_step(OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
         if ($urandom_range(0, 1))
            push_step(OP_RANGE, 16'($urandom_range(near_limit, 65535)), 1'b1,
                      16'($urandom));
      end
      if ($urandom_range(0, 7) == 0)
         push_step(OP_RANGE, 16'($urandom), 1'b0, 16'($urandom));
      push_step(OP_RANGE,
                (near_limit == 0) ? 16'd0 : 16'($urandom_range(0, near_limit - 1)),
                1'b1, 16'($urandom));
      push_ticks(1 + ticks_for(seq_cfg.backup_ticks));
      push_ticks(ticks_for(seq_cfg.pause_ticks));
      heading = 16'($urandom);
      push_step(OP_YAW, 16'($urandom), 1'($urandom_range(0, 1)), heading);
      if ($urandom_range(0, 3) == 0) begin
         // Spin that runs out of time instead of reaching the target.
         n = ticks_for(seq_cfg.spin_timeout_ticks) + 1;
         repeat (n) begin
            push_step(OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
            if ($urandom_range(0, 3) == 0) begin
               heading = heading + 16'($urandom_range(0, 64));
               push_step(OP_YAW, 16'($urandom), 1'($urandom_range(0, 1)), heading);
            end
         end
      end else begin
         sign = $urandom_range(0, 1) ? 1 : -1;
         span = int'(seq_cfg.spin_target) / $urandom_range(2, 12) + $urandom_range(1, 64);
         if (span > 32767)
            span = 32767;
         turn_est = 0;
         n = 0;
         do begin
            if ($urandom_range(0, 15) == 0)
               step = 32768;
            else
               step = $urandom_range(span / 2, span);
            if ($urandom_range(0, 5) == 0)
               step = -step;
            step = step * sign;
            wrapped = step[15:0];
            heading = heading + wrapped;
            turn_est = turn_est + int'(wrapped);
            push_step(OP_YAW, 16'($urandom), 1'($urandom_range(0, 1)), heading);
            if ($urandom_range(0, 4) == 0)
               push_step(OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)), 16'($urandom));
            n++;
         end while (n < 40 && ((turn_est < 0) ? -turn_est : turn_est) < int'(seq_cfg.spin_target));
      end
      push_ticks(ticks_for(seq_cfg.pause_ticks));
   endtask

   task automatic run_phase(cfg_type c, int budget, bit calm);
      settle();
      load_settings(c);
      idle_on = !calm && ($urandom_range(0, 3) != 0);
      planned_items = 0;
      while (planned_items < budget)
         plan_avoidance_cycle();
   endtask

   initial begin
      cfg_type plan;
      int drain;
      seq_cfg.obstacle_distance_mm = RST_OBSTACLE_DISTANCE;
      seq_cfg.cruise_speed = RST_CRUISE_SPEED;
      seq_cfg.reverse_speed = RST_REVERSE_SPEED;
      seq_cfg.spin_rate = RST_SPIN_RATE;
      seq_cfg.backup_ticks = RST_BACKUP_TICKS;
      seq_cfg.pause_ticks = RST_PAUSE_TICKS;
      seq_cfg.spin_timeout_ticks = RST_SPIN_TIMEOUT;
      seq_cfg.spin_target = RST_SPIN_TARGET;
      seq_mode = MODE_FORWARD;
      seq_ticks = '0;
      seq_obstacle = 1'b0;
      seq_primed = 1'b0;
      seq_last_yaw = '0;
      seq_turned = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register values straight out of reset.
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      push_item(OP_RANGE, 16'd400, 1'b1, 16'sd0);
      push_item(OP_RANGE, 16'd399, 1'b0, 16'sd0);
      push_item(OP_UNUSED, 16'hFFFF, 1'b1, -16'sd1);
      settle();

      plan.obstacle_distance_mm = 16'd1000;
      plan.cruise_speed = 12'sd2047;
      plan.reverse_speed = -12'sd2048;
      plan.spin_rate = -12'sd2048;
      plan.backup_ticks = 10'd1;
      plan.pause_ticks = 10'd0;
      plan.spin_timeout_ticks = 10'd2;
      plan.spin_target = 16'hFFFF;
      load_settings(plan);
      push_item(OP_TICK, 16'hFFFF, 1'b1, 16'sd0);
      push_item(OP_RANGE, 16'd0, 1'b0, 16'sd0);
      push_item(OP_YAW, 16'd0, 1'b0, 16'sd1234);
      push_item(OP_RANGE, 16'd999, 1'b1, 16'sd0);
      push_item(OP_RANGE, 16'd1000, 1'b1, 16'sd0);
      push_item(OP_RANGE, 16'd0, 1'b1, 16'sd0);
      // The tick after a near range enters backup without a command.
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      push_item(OP_RANGE, 16'd0, 1'b1, 16'sd0);
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      // Spin: the first heading only primes; the next two cross the wrap point.
      push_item(OP_YAW, 16'd0, 1'b0, 16'sh7FFF);
      push_item(OP_YAW, 16'd0, 1'b0, -16'sh8000);
      push_item(OP_YAW, 16'd0, 1'b0, 16'sd0);
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      push_item(OP_YAW, 16'd0, 1'b0, 16'sd100);
      push_item(OP_RANGE, 16'd0, 1'b1, 16'sd0);
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      push_item(OP_TICK, 16'd0, 1'b0, 16'sd0);
      push_item(OP_UNUSED, 16'hFFFF, 1'b1, -16'sd1);

      plan.obstacle_distance_mm = RST_OBSTACLE_DISTANCE;
      plan.cruise_speed = RST_CRUISE_SPEED;
      plan.reverse_speed = RST_REVERSE_SPEED;
      plan.spin_rate = RST_SPIN_RATE;
      plan.backup_ticks = RST_BACKUP_TICKS;
      plan.pause_ticks = RST_PAUSE_TICKS;
      plan.spin_timeout_ticks = RST_SPIN_TIMEOUT;
      plan.spin_target = RST_SPIN_TARGET;
      run_phase(plan, 300, 1'b0);

      plan = '0;
      run_phase(plan, 100, 1'b0);

      plan.obstacle_distance_mm = 16'hFFFF;
      plan.cruise_speed = -12'sd2048;
      plan.reverse_speed = 12'sd2047;
      plan.spin_rate = 12'sd2047;
      plan.backup_ticks = 10'd1023;
      plan.pause_ticks = 10'd1023;
      plan.spin_timeout_ticks = 10'd1022;
      plan.spin_target = 16'hFFFF;
      run_phase(plan, 150, 1'b0);

      // Zero dwell times with every range below 65535 near: the modes cycle as fast as possible.
      plan = '0;
      plan.obstacle_distance_mm = 16'hFFFF;
      plan.spin_rate = 12'sd1;
      plan.reverse_speed = -12'sd1;
      run_phase(plan, 200, 1'b0);

      repeat (4) run_phase(random_settings(), 250, 1'b0);
      run_phase(random_settings(), 250, 1'b1);

      while (pending_items.size() != 0)
         @(negedge clock);
      drain = 0;
      while (expected_cmds.size() != 0 && drain < 2000) begin
         @(negedge clock);
         drain++;
      end
      repeat (10) @(negedge clock);
      if (expected_cmds.size() != 0)
         report_mismatch($sformatf("%0d commands never arrived", expected_cmds.size()));
      if (error_count == 0)
         $display("PASS obstacle_backup_spin_sequencer_core");
      else
         $display("FAIL obstacle_backup_spin_sequencer_core");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL obstacle_backup_spin_sequencer_core");
      $finish;
   end

endmodule
